@@ sv/tkm_pkg.sv @@
// ----------------------------------------------------------------------------
// tkm_pkg: shared constants and types for the timestamp k-way merge
// Queue geometry, derived widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tkm_pkg;

	localparam int NUM_QUEUES   = 8;
	localparam int QUEUE_DEPTH  = 64;
	localparam int HANDLE_WIDTH = 32;

	localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW      = $clog2(QUEUE_DEPTH);
	localparam int FW      = $clog2(QUEUE_DEPTH + 1);
	localparam int AW      = $clog2(SLOTS);
	localparam int TW      = $clog2(SLOTS + 1);
	localparam int STAMP_W = 64;
	localparam int WORD_W  = STAMP_W + HANDLE_WIDTH;

	// field widths on the ports
	localparam int SEL_W    = 3;
	localparam int HIN_W    = 32;
	localparam int SRC_W    = 3;
	localparam int COUNT_W  = 10;
	localparam int IN_DW    = 104;
	localparam int OUT_DW   = 112;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	typedef enum logic [1:0] {
		STAT_LOADED    = 2'd0,
		STAT_DELIVERED = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_REJECTED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN_ADDR,
		S_SCAN_CMP,
		S_FINISH,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

@@ sv/timestamp_kway_merge.sv @@
// ----------------------------------------------------------------------------
// timestamp_kway_merge: k-way merge of per-source fragment queues by timestamp
// Loads append (timestamp, handle) to one queue; takes return the fragment
// with the smallest front timestamp, ties going to the lowest queue number.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+----------
//  s_*     | in  | queue_sel[2:0] stamp_in[66:3]              | op
//          |     | handle_in[98:67], zero pad [103:99]        |
//  m_*     | out | stamp_out[63:0] handle_out[95:64]          | status
//          |     | source_out[98:96] drained[99]              |
//          |     | held_count[109:100], zero pad [111:110]    |
//
// One transaction at a time: a load passes S_LOAD, then S_RESP; a take passes
// S_SCAN_ADDR for every queue, with a RAM read and then an S_SCAN_CMP compare
// for each non-empty front, then S_FINISH and S_RESP, and returns to S_IDLE.
// Reset clears the queue pointers, fill levels and held count, not the store.
// A stalled m_tready holds only the final hand-off: the next input is still
// taken, and the one after it waits until the older result has moved out.
`default_nettype none

module timestamp_kway_merge (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input transactions
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [tkm_pkg::IN_DW-1:0]     s_tdata,  // queue_sel, stamp_in, handle_in
	input  wire logic                          s_tuser,  // op
	// result transactions
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [tkm_pkg::OUT_DW-1:0]    m_tdata,  // stamp, handle, source, drained, count
	output logic      [1:0]                    m_tuser   // status
);

	tkm_pkg::state_t state_q, state_d;

	// queue bookkeeping
	logic [tkm_pkg::PW-1:0] head_q [tkm_pkg::NUM_QUEUES];
	logic [tkm_pkg::FW-1:0] fill_q [tkm_pkg::NUM_QUEUES];
	logic [tkm_pkg::TW-1:0] total_q;

	// latched input transaction
	logic [tkm_pkg::QW-1:0]           qsel_q;
	logic                             bad_sel_q;
	logic [tkm_pkg::STAMP_W-1:0]      stamp_in_q;
	logic [tkm_pkg::HANDLE_WIDTH-1:0] handle_in_q;

	// scan state
	logic [tkm_pkg::QW-1:0]           scan_q;
	logic                             found_q;
	logic [tkm_pkg::QW-1:0]           best_q;
	logic [tkm_pkg::WORD_W-1:0]       best_word_q;

	// pending result
	tkm_pkg::status_t                 res_status_q;
	logic [tkm_pkg::STAMP_W-1:0]      res_stamp_q;
	logic [tkm_pkg::HIN_W-1:0]        res_handle_q;
	logic [tkm_pkg::SRC_W-1:0]        res_source_q;
	logic                             res_drained_q;
	logic [tkm_pkg::COUNT_W-1:0]      res_count_q;

	// output register
	logic                             m_valid_q;
	logic [tkm_pkg::OUT_DW-1:0]       m_data_q;
	logic [1:0]                       m_user_q;

	// RAM port
	logic                             ram_we, ram_re;
	logic [tkm_pkg::AW-1:0]           ram_addr;
	logic [tkm_pkg::WORD_W-1:0]       ram_wdata, ram_rdata;

	logic                             s_accept;
	logic                             out_free;
	logic                             scan_last;
	logic                             load_reject;
	logic [tkm_pkg::PW:0]             slot_sum;
	logic [tkm_pkg::PW-1:0]           slot;
	logic [tkm_pkg::AW-1:0]           load_addr, scan_addr;
	logic [tkm_pkg::STAMP_W-1:0]      rd_stamp;
	logic [tkm_pkg::TW-1:0]           total_dec;

	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign scan_last = (scan_q == tkm_pkg::QW'(tkm_pkg::NUM_QUEUES - 1));

	// reject an out-of-range queue or a full one
	assign load_reject = bad_sel_q
		|| (fill_q[qsel_q] == tkm_pkg::FW'(tkm_pkg::QUEUE_DEPTH));

	// tail slot: head + fill, wrapped once
	assign slot_sum = (tkm_pkg::PW+1)'(head_q[qsel_q]) + (tkm_pkg::PW+1)'(fill_q[qsel_q]);
	assign slot = (slot_sum >= (tkm_pkg::PW+1)'(tkm_pkg::QUEUE_DEPTH))
		? tkm_pkg::PW'(slot_sum - (tkm_pkg::PW+1)'(tkm_pkg::QUEUE_DEPTH))
		: tkm_pkg::PW'(slot_sum);

	assign load_addr = tkm_pkg::AW'(qsel_q) * tkm_pkg::AW'(tkm_pkg::QUEUE_DEPTH)
		+ tkm_pkg::AW'(slot);
	assign scan_addr = tkm_pkg::AW'(scan_q) * tkm_pkg::AW'(tkm_pkg::QUEUE_DEPTH)
		+ tkm_pkg::AW'(head_q[scan_q]);

	assign ram_wdata = {handle_in_q, stamp_in_q};
	assign rd_stamp  = ram_rdata[tkm_pkg::STAMP_W-1:0];
	assign total_dec = total_q - tkm_pkg::TW'(1);

	tkm_ram #(
		.WIDTH(tkm_pkg::WORD_W),
		.DEPTH(tkm_pkg::SLOTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tkm_pkg::S_IDLE: begin
				if (s_accept) begin
					state_d = (s_tuser == tkm_pkg::OP_LOAD) ? tkm_pkg::S_LOAD
						: tkm_pkg::S_SCAN_ADDR;
				end
			end
			tkm_pkg::S_LOAD: state_d = tkm_pkg::S_RESP;
			tkm_pkg::S_SCAN_ADDR: begin
				if (fill_q[scan_q] != '0) begin
					state_d = tkm_pkg::S_SCAN_CMP;
				end else if (scan_last) begin
					state_d = tkm_pkg::S_FINISH;
				end
			end
			tkm_pkg::S_SCAN_CMP: begin
				state_d = scan_last ? tkm_pkg::S_FINISH : tkm_pkg::S_SCAN_ADDR;
			end
			tkm_pkg::S_FINISH: state_d = tkm_pkg::S_RESP;
			tkm_pkg::S_RESP: begin
				if (out_free) begin
					state_d = tkm_pkg::S_IDLE;
				end
			end
			default: state_d = tkm_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = scan_addr;
		case (state_q)
			tkm_pkg::S_IDLE: s_tready = 1'b1;
			tkm_pkg::S_LOAD: begin
				ram_we   = !load_reject;
				ram_addr = load_addr;
			end
			tkm_pkg::S_SCAN_ADDR: ram_re = (fill_q[scan_q] != '0);
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tkm_pkg::S_IDLE;
			total_q   <= '0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < tkm_pkg::NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			// load the output register on hand-off, else drop it once taken
			if (state_q == tkm_pkg::S_RESP && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				tkm_pkg::S_LOAD: begin
					if (!load_reject) begin
						fill_q[qsel_q] <= fill_q[qsel_q] + tkm_pkg::FW'(1);
						total_q        <= total_q + tkm_pkg::TW'(1);
					end
				end
				tkm_pkg::S_FINISH: begin
					if (found_q) begin
						// advance the winning queue's head, wrapping at the depth
						head_q[best_q] <= (head_q[best_q] == tkm_pkg::PW'(tkm_pkg::QUEUE_DEPTH - 1))
							? '0 : head_q[best_q] + tkm_pkg::PW'(1);
						fill_q[best_q] <= fill_q[best_q] - tkm_pkg::FW'(1);
						total_q        <= total_dec;
					end
				end
				default: begin
					total_q <= total_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			qsel_q      <= tkm_pkg::QW'(s_tdata[tkm_pkg::SEL_W-1:0]);
			bad_sel_q   <= (32'(s_tdata[tkm_pkg::SEL_W-1:0]) >= tkm_pkg::NUM_QUEUES);
			stamp_in_q  <= s_tdata[tkm_pkg::SEL_W +: tkm_pkg::STAMP_W];
			handle_in_q <= tkm_pkg::HANDLE_WIDTH'(
				s_tdata[tkm_pkg::SEL_W + tkm_pkg::STAMP_W +: tkm_pkg::HIN_W]);
			scan_q      <= '0;
			found_q     <= 1'b0;
		end
		case (state_q)
			tkm_pkg::S_LOAD: begin
				res_status_q  <= load_reject ? tkm_pkg::STAT_REJECTED : tkm_pkg::STAT_LOADED;
				res_stamp_q   <= '0;
				res_handle_q  <= '0;
				res_source_q  <= '0;
				res_drained_q <= 1'b0;
				res_count_q   <= load_reject ? tkm_pkg::COUNT_W'(total_q)
					: tkm_pkg::COUNT_W'(total_q + tkm_pkg::TW'(1));
			end
			tkm_pkg::S_SCAN_ADDR: begin
				if (fill_q[scan_q] == '0 && !scan_last) begin
					scan_q <= scan_q + tkm_pkg::QW'(1);
				end
			end
			tkm_pkg::S_SCAN_CMP: begin
				// strict less-than keeps the lowest queue on equal stamps
				if (!found_q || rd_stamp < best_word_q[tkm_pkg::STAMP_W-1:0]) begin
					found_q     <= 1'b1;
					best_q      <= scan_q;
					best_word_q <= ram_rdata;
				end
				if (!scan_last) begin
					scan_q <= scan_q + tkm_pkg::QW'(1);
				end
			end
			tkm_pkg::S_FINISH: begin
				if (found_q) begin
					res_status_q  <= tkm_pkg::STAT_DELIVERED;
					res_stamp_q   <= best_word_q[tkm_pkg::STAMP_W-1:0];
					res_handle_q  <= tkm_pkg::HIN_W'(best_word_q[tkm_pkg::WORD_W-1:tkm_pkg::STAMP_W]);
					res_source_q  <= tkm_pkg::SRC_W'(best_q);
					res_drained_q <= (total_dec == '0);
					res_count_q   <= tkm_pkg::COUNT_W'(total_dec);
				end else begin
					res_status_q  <= tkm_pkg::STAT_EMPTY;
					res_stamp_q   <= '0;
					res_handle_q  <= '0;
					res_source_q  <= '0;
					res_drained_q <= 1'b0;
					res_count_q   <= '0;
				end
			end
			tkm_pkg::S_RESP: begin
				// hand the result to the output register once it is free
				if (out_free) begin
					m_user_q <= res_status_q;
					m_data_q <= {2'b00, res_count_q, res_drained_q, res_source_q,
						res_handle_q, res_stamp_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

`default_nettype wire

@@ sv/tkm_ram.sv @@
// ----------------------------------------------------------------------------
// tkm_ram: generic single-port RAM
// One write and one read per cycle, both at the same address; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tkm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire
